// ----- hw/rtl/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants and CORDIC arctangent table for the Euler to quaternion block.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 15;
  localparam int OUT_W             = 16;
  localparam int ITERS             = 32;
  localparam int IDX_W             = 5;
  localparam int CW                = 34;   // cordic x/y/z datapath width
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [CW-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      5'd30: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/e2q_if.sv -----
// ----------------------------------------------------------------------------
// e2q_in_if / e2q_out_if
// Valid/ready channels for angle beats and quaternion beats.
// ----------------------------------------------------------------------------
interface e2q_in_if #(parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [e2q_pkg::OUT_W-1:0] quat_w;
  logic signed [e2q_pkg::OUT_W-1:0] quat_x;
  logic signed [e2q_pkg::OUT_W-1:0] quat_y;
  logic signed [e2q_pkg::OUT_W-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- hw/rtl/e2q_cordic.sv -----
// ----------------------------------------------------------------------------
// e2q_cordic
// One lane: pipelined rotation-mode CORDIC, one iteration per stage,
// giving sine and cosine of the half angle in Q4.30.
// ----------------------------------------------------------------------------
module e2q_cordic #(
  parameter int ANGLE_BITS = e2q_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [ANGLE_BITS-1:0]    angle,
  output logic signed [e2q_pkg::CW-1:0]   sin_o,
  output logic signed [e2q_pkg::CW-1:0]   cos_o
);
  localparam int CW = e2q_pkg::CW;
  localparam int N  = e2q_pkg::ITERS;

  logic signed [CW-1:0] x_r [N+1];
  logic signed [CW-1:0] y_r [N+1];
  logic signed [CW-1:0] z_r [N+1];
  logic signed [32:0]   scaled;

  // 32-bit binary angle then halved
  assign scaled = 33'(signed'({angle, {(33 - ANGLE_BITS){1'b0}}})) >>> (33 - 32);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= e2q_pkg::CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= CW'(scaled >>> 1);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - e2q_pkg::atan_lut(e2q_pkg::IDX_W'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + e2q_pkg::atan_lut(e2q_pkg::IDX_W'(i));
        end
      end
    end
  end

  assign sin_o = y_r[N];
  assign cos_o = x_r[N];
endmodule

// ----- hw/rtl/e2q_merge.sv -----
// ----------------------------------------------------------------------------
// e2q_merge
// Combines lane results: pair products, yaw products, sum, round, saturate.
// Three register stages.
// ----------------------------------------------------------------------------
module e2q_merge #(
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [e2q_pkg::CW-1:0]     sr, cr, sp, cp, sy, cy,
  output logic signed [e2q_pkg::OUT_W-1:0]  qw, qx, qy, qz
);
  localparam int CW = e2q_pkg::CW;
  localparam int PW = 2 * CW;
  localparam int SH = 60 - OUT_FRAC_BITS;

  logic signed [PW-1:0] cc_p, cs_p, sc_p, ss_p;
  logic signed [CW-1:0] cc_r, cs_r, sc_r, ss_r, sy_r, cy_r;
  logic signed [PW-1:0] ycc_r, yss_r, ysc_r, ycs_r, ccy_r, ssy_r, scy_r, csy_r;
  logic signed [PW-1:0] w_s, x_s, y_s, z_s;

  function automatic logic signed [CW-1:0] rnd30(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + (PW'(1) <<< 29)) >>> 30;
    return t[CW-1:0];
  endfunction

  function automatic logic signed [e2q_pkg::OUT_W-1:0] fin(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    t  = (v + (PW'(1) <<< (SH - 1))) >>> SH;
    hi = (PW'(1) <<< OUT_FRAC_BITS) - PW'(1);
    lo = -(PW'(1) <<< OUT_FRAC_BITS);
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    if (t > PW'(32767)) t = PW'(32767);
    if (t < -PW'(32768)) t = -PW'(32768);
    return t[e2q_pkg::OUT_W-1:0];
  endfunction

  assign cc_p = PW'(cr) * PW'(cp);
  assign cs_p = PW'(cr) * PW'(sp);
  assign sc_p = PW'(sr) * PW'(cp);
  assign ss_p = PW'(sr) * PW'(sp);

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= rnd30(cc_p);
      cs_r <= rnd30(cs_p);
      sc_r <= rnd30(sc_p);
      ss_r <= rnd30(ss_p);
      sy_r <= sy;
      cy_r <= cy;
      ycc_r <= PW'(cy_r) * PW'(cc_r);
      yss_r <= PW'(sy_r) * PW'(ss_r);
      ysc_r <= PW'(cy_r) * PW'(sc_r);
      ycs_r <= PW'(sy_r) * PW'(cs_r);
      ccy_r <= PW'(sy_r) * PW'(cc_r);
      ssy_r <= PW'(cy_r) * PW'(ss_r);
      scy_r <= PW'(sy_r) * PW'(sc_r);
      csy_r <= PW'(cy_r) * PW'(cs_r);
      qw <= fin(w_s);
      qx <= fin(x_s);
      qy <= fin(y_s);
      qz <= fin(z_s);
    end
  end

  assign w_s = ycc_r + yss_r;
  assign x_s = ysc_r - ycs_r;
  assign y_s = csy_r + scy_r;
  assign z_s = ccy_r - ssy_r;
endmodule

// ----- hw/rtl/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion
// An input beat passes the angle register, the CORDIC stages and the merge stages;
// throughput one beat per cycle unless stalled, set by the fully pipelined lanes.
// The whole pipeline stalls when the output holds and is not taken.
// Reset (rst_n, synchronous) clears only the stage valid bits.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int ANGLE_BITS    = e2q_pkg::ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  e2q_in_if.sink    in_ch,
  e2q_out_if.source out_ch
);
  localparam int CW  = e2q_pkg::CW;
  localparam int LAT = e2q_pkg::ITERS + 4;

  logic           en;
  logic [LAT-1:0] vld_r;
  logic signed [CW-1:0] sr, cr, sp, cp, sy, cy;

  // pipeline advances unless the last beat is held
  assign en           = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .en(en), .angle(in_ch.roll_angle), .sin_o(sr), .cos_o(cr));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(in_ch.pitch_angle), .sin_o(sp), .cos_o(cp));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(in_ch.yaw_angle), .sin_o(sy), .cos_o(cy));

  e2q_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
    .clk(clk), .en(en),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .qw(out_ch.quat_w), .qx(out_ch.quat_x), .qy(out_ch.quat_y), .qz(out_ch.quat_z));
endmodule

// ----- tb/euler_to_quaternion_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_test
// Drives roll/pitch/yaw beats into the block and compares every quaternion
// beat with a bit-exact CORDIC-based predictor, under random and forced stalls.
// ----------------------------------------------------------------------------
module euler_to_quaternion_test;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  e2q_in_if  in_ch ();
  e2q_out_if out_ch ();

  euler_to_quaternion dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  quat_t quat_expected[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_off = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("euler_to_quaternion_test failed");
    $finish;
  end

  function automatic longint shift_right(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // sine and cosine of half a 16-bit binary angle, Q30
  task automatic half_sin_cos(input logic signed [15:0] ang, output longint s,
                              output longint c);
    longint z, x, y, dx, dy;
    z = (longint'(ang) <<< 16) >>> 1;
    x = 652032874;
    y = 0;
    for (int i = 0; i < e2q_pkg::ITERS; i++) begin
      dx = shift_right(y, i);
      dy = shift_right(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(e2q_pkg::atan_lut(i[e2q_pkg::IDX_W-1:0]));
      end else begin
        x += dx; y -= dy; z += longint'(e2q_pkg::atan_lut(i[e2q_pkg::IDX_W-1:0]));
      end
    end
    s = y;
    c = x;
  endtask

  function automatic logic signed [15:0] to_q15(longint q60);
    longint v;
    v = round_q(q60, 60 - 15);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_quat(input logic signed [15:0] r, p, yw, output quat_t q);
    longint sr, cr, sp, cp, sy, cy, cc, cs, sc, ss;
    half_sin_cos(r, sr, cr);
    half_sin_cos(p, sp, cp);
    half_sin_cos(yw, sy, cy);
    cc = round_q(cr * cp, 30);
    cs = round_q(cr * sp, 30);
    sc = round_q(sr * cp, 30);
    ss = round_q(sr * sp, 30);
    q.w = to_q15(cy * cc + sy * ss);
    q.x = to_q15(cy * sc - sy * cs);
    q.y = to_q15(cy * cs + sy * sc);
    q.z = to_q15(sy * cc - cy * ss);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  // receiver ready, random or held off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker
  initial begin
    quat_t q;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (quat_expected.size() == 0) begin
          report("unexpected beat", out_ch.quat_w, 0);
        end else begin
          q = quat_expected.pop_front();
          if (out_ch.quat_w !== q.w) report("quat_w", out_ch.quat_w, q.w);
          if (out_ch.quat_x !== q.x) report("quat_x", out_ch.quat_x, q.x);
          if (out_ch.quat_y !== q.y) report("quat_y", out_ch.quat_y, q.y);
          if (out_ch.quat_z !== q.z) report("quat_z", out_ch.quat_z, q.z);
        end
      end
    end
  end

  task automatic send_angles(input logic signed [15:0] r, p, yw);
    quat_t q;
    while (($urandom_range(99) < send_idle_pct)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.roll_angle  <= r;
    in_ch.pitch_angle <= p;
    in_ch.yaw_angle   <= yw;
    predict_quat(r, p, yw, q);
    quat_expected.push_back(q);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (quat_expected.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic signed [15:0] edges[6] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000,
                                      16'shc000, 16'sh0001};
    foreach (edges[i]) send_angles(edges[i], '0, '0);
    foreach (edges[i]) send_angles('0, edges[i], '0);
    foreach (edges[i]) send_angles('0, '0, edges[i]);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_angles(16'shffff, 16'shffff, 16'shffff);
    send_angles(16'sh5555, 16'shaaaa, 16'sh2aaa);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_angles(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_off = 200;
    send_idle_pct = 0;
    test_random(80);
    drain();
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.roll_angle  <= '0;
    in_ch.pitch_angle <= '0;
    in_ch.yaw_angle   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain();
    send_idle_pct = 21; recv_idle_pct = 52;
    test_random(140);
    send_idle_pct = 52; recv_idle_pct = 21;
    test_random(140);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(140);
    test_backpressure();

    repeat (60) @(posedge clk);
    if (mismatches == 0 && quat_expected.size() == 0) begin
      $display("euler_to_quaternion_test passed");
    end else begin
      $display("euler_to_quaternion_test failed");
    end
    $finish;
  end

endmodule
